[rtl/core/sspq_pkg.sv]
// ----------------------------------------------------------------------------
// sspq_pkg
// Shared types and codes for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package sspq_pkg;

  localparam int ValueW  = 32;
  localparam int PrioW   = 16;
  localparam int StatusW = 2;
  localparam int OccW    = 5;

  // Operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] ST_INSERTED  = 2'd0;
  localparam logic [StatusW-1:0] ST_REMOVED   = 2'd1;
  localparam logic [StatusW-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [StatusW-1:0] ST_OVERFLOW  = 2'd3;

  typedef logic signed [ValueW-1:0] value_t;
  typedef logic        [PrioW-1:0]  prio_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic ins_en;    // an insert beat is applied this cycle
    logic rem_en;    // a remove beat is applied this cycle
    logic occupied;  // this slot holds an entry
    logic at_tail;   // this slot is the first free one
  } cell_ctl_t;

endpackage

[rtl/core/sspq_cell.sv]
// ----------------------------------------------------------------------------
// sspq_cell
// One slot of the sorted queue: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module sspq_cell (
  input  logic               clk_i,
  input  sspq_pkg::cell_ctl_t ctl_i,
  input  sspq_pkg::value_t   new_value_i,
  input  sspq_pkg::prio_t    new_prio_i,
  input  sspq_pkg::value_t   left_value_i,
  input  sspq_pkg::prio_t    left_prio_i,
  input  logic               left_ins_here_i,
  input  sspq_pkg::value_t   right_value_i,
  input  sspq_pkg::prio_t    right_prio_i,
  output sspq_pkg::value_t   value_o,
  output sspq_pkg::prio_t    prio_o,
  output logic               ins_here_o
);
  import sspq_pkg::*;

  value_t value_q, value_d;
  prio_t  prio_q, prio_d;

  // Flag a slot at or behind the insert point: held entry ranks strictly after
  // the new one, or this is the first free slot
  assign ins_here_o = (ctl_i.occupied && (new_prio_i < prio_q)) || ctl_i.at_tail;

  // Select shift-right, load, shift-left or hold
  always_comb begin
    value_d = value_q;
    prio_d  = prio_q;
    if (ctl_i.ins_en) begin
      if (left_ins_here_i) begin
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else if (ins_here_o) begin
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (ctl_i.rem_en) begin
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

[rtl/core/stable_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue held as a sorted chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one operation per beat:
//   opcode_i selects insert or remove; item_value_i and item_priority_i are
//   the entry for an insert. Lowest priority number leaves first, equal
//   priorities leave in arrival order.
//   Output channel (out_valid_o / out_stall_i) returns exactly one result per
//   operation: status, the removed head entry (zero unless removed) and the
//   occupancy after the operation.
//   The result is registered. Throughput is one operation per cycle while
//   the receiver does not stall: every cell compares its priority with the
//   incoming one in parallel and shifts with its neighbor in the same cycle.
//   While the receiver stalls, the held result stays put and in_stall_o is
//   raised, so at most one result is buffered.
//   Reset empties the queue at once; slot contents are not cleared and are
//   never observed before being written.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  opcode_i,
  input  logic signed [sspq_pkg::ValueW-1:0]    item_value_i,
  input  logic        [sspq_pkg::PrioW-1:0]     item_priority_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic        [sspq_pkg::StatusW-1:0]   status_o,
  output logic signed [sspq_pkg::ValueW-1:0]    removed_value_o,
  output logic        [sspq_pkg::PrioW-1:0]     removed_priority_o,
  output logic        [sspq_pkg::OccW-1:0]      occupancy_o
);
  import sspq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  value_t          rval_q, rval_d;
  prio_t           rprio_q, rprio_d;
  logic [OccW-1:0] occ_q;
  logic [CntW+OccW-1:0] count_ext;

  logic accept, full, empty, ins_en, rem_en;

  value_t cell_value [QUEUE_DEPTH];
  prio_t  cell_prio  [QUEUE_DEPTH];
  logic   cell_ins_here [QUEUE_DEPTH];

  // Accept when the result register is free or being drained
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(QUEUE_DEPTH));
  assign empty      = (count_q == '0);
  assign ins_en     = accept && (opcode_i == OP_INSERT) && !full;
  assign rem_en     = accept && (opcode_i == OP_REMOVE) && !empty;

  // Build the slot chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    value_t    left_value, right_value;
    prio_t     left_prio, right_prio;
    logic      left_ins_here;

    assign ctl.ins_en   = ins_en;
    assign ctl.rem_en   = rem_en;
    assign ctl.occupied = (count_q > CntW'(i));
    assign ctl.at_tail  = (count_q == CntW'(i));

    if (i == 0) begin : g_head
      assign left_value    = cell_value[i];
      assign left_prio     = cell_prio[i];
      assign left_ins_here = 1'b0;
    end else begin : g_body
      assign left_value    = cell_value[i-1];
      assign left_prio     = cell_prio[i-1];
      assign left_ins_here = cell_ins_here[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_value = cell_value[i];
      assign right_prio  = cell_prio[i];
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_prio  = cell_prio[i+1];
    end

    sspq_cell u_cell (
      .clk_i           (clk_i),
      .ctl_i           (ctl),
      .new_value_i     (item_value_i),
      .new_prio_i      (item_priority_i),
      .left_value_i    (left_value),
      .left_prio_i     (left_prio),
      .left_ins_here_i (left_ins_here),
      .right_value_i   (right_value),
      .right_prio_i    (right_prio),
      .value_o         (cell_value[i]),
      .prio_o          (cell_prio[i]),
      .ins_here_o      (cell_ins_here[i])
    );
  end

  // Form the result and the next count
  always_comb begin
    count_d  = count_q;
    status_d = ST_INSERTED;
    rval_d   = '0;
    rprio_d  = '0;
    if (opcode_i == OP_INSERT) begin
      if (full) begin
        status_d = ST_OVERFLOW;
      end else begin
        status_d = ST_INSERTED;
        count_d  = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = ST_UNDERFLOW;
      end else begin
        status_d = ST_REMOVED;
        rval_d   = cell_value[0];
        rprio_d  = cell_prio[0];
        count_d  = count_q - CntW'(1);
      end
    end
  end

  assign count_ext = {{OccW{1'b0}}, count_d};

  // Track the entry count and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rval_q   <= rval_d;
      rprio_q  <= rprio_d;
      occ_q    <= count_ext[OccW-1:0];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_value_o    = rval_q;
  assign removed_priority_o = rprio_q;
  assign occupancy_o        = occ_q;

endmodule

[verif/sspq_checker.sv]
// ----------------------------------------------------------------------------
// sspq_checker
// Watches both channels of the stable sorted priority queue, keeps its own
// sorted copy of the queue, and compares every result beat with the oldest
// prediction. Hands failure and progress counts to the testbench top.
// ----------------------------------------------------------------------------
module sspq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             opcode_i,
  input  sspq_pkg::value_t                 item_value_i,
  input  sspq_pkg::prio_t                  item_priority_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic [sspq_pkg::StatusW-1:0]     status_i,
  input  sspq_pkg::value_t                 removed_value_i,
  input  sspq_pkg::prio_t                  removed_priority_i,
  input  logic [sspq_pkg::OccW-1:0]        occupancy_i,
  output int                               errors_o,
  output int                               pending_o,
  output int                               checked_o,
  output int                               underflows_o,
  output int                               overflows_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sspq_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    value_t             value;
    prio_t              prio;
    logic [OccW-1:0]    occ;
  } queue_result_t;

  // Shadow copy of the sorted queue, slot 0 is the head
  value_t        shadow_val [QUEUE_DEPTH];
  prio_t         shadow_pri [QUEUE_DEPTH];
  int            shadow_count;
  queue_result_t due_results [$];
  int            fails;
  int            checked;
  int            underflows;
  int            overflows;

  // Apply one operation to the shadow queue and return the result it causes
  task automatic apply_queue_op(input logic op, input value_t v, input prio_t p,
                                output queue_result_t r);
    int pos;
    r.status = ST_INSERTED;
    r.value  = '0;
    r.prio   = '0;
    if (op == OP_INSERT) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = ST_OVERFLOW;
      end else begin
        // land behind every entry with priority less than or equal
        pos = shadow_count;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (p < shadow_pri[i]) pos = i;
        end
        for (int i = shadow_count; i > pos; i--) begin
          shadow_val[i] = shadow_val[i-1];
          shadow_pri[i] = shadow_pri[i-1];
        end
        shadow_val[pos] = v;
        shadow_pri[pos] = p;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = ST_UNDERFLOW;
      end else begin
        r.status = ST_REMOVED;
        r.value  = shadow_val[0];
        r.prio   = shadow_pri[0];
        for (int i = 1; i < shadow_count; i++) begin
          shadow_val[i-1] = shadow_val[i];
          shadow_pri[i-1] = shadow_pri[i];
        end
        shadow_count--;
      end
    end
    r.occ = shadow_count[OccW-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    queue_result_t got;
    queue_result_t want;
    queue_result_t fresh;
    if (!rst_ni) begin
      shadow_count = 0;
      due_results.delete();
      fails      = 0;
      checked    = 0;
      underflows = 0;
      overflows  = 0;
    end else begin
      // Compare the result beat first so a spurious one is never paired
      // with a prediction made at this same edge
      if (out_valid_i && !out_stall_i) begin
        got.status = status_i;
        got.value  = removed_value_i;
        got.prio   = removed_priority_i;
        got.occ    = occupancy_i;
        if (due_results.size() == 0) begin
          if (fails < 10) begin
            $display("[%0t] unexpected result beat: status %0d value %0d prio %0d occ %0d",
                     $realtime, got.status, got.value, got.prio, got.occ);
          end
          fails++;
        end else begin
          want = due_results.pop_front();
          checked++;
          if (want.status == ST_UNDERFLOW) underflows++;
          if (want.status == ST_OVERFLOW) overflows++;
          if (got !== want) begin
            if (fails < 10) begin
              $display("[%0t] result mismatch: expected status %0d value %0d prio %0d occ %0d",
                       $realtime, want.status, want.value, want.prio, want.occ);
              $display("                      got      status %0d value %0d prio %0d occ %0d",
                       got.status, got.value, got.prio, got.occ);
            end
            fails++;
          end
        end
      end
      // Predict the result of an accepted operation beat
      if (in_valid_i && !in_stall_i) begin
        apply_queue_op(opcode_i, item_value_i, item_priority_i, fresh);
        due_results.push_back(fresh);
      end
    end
    errors_o     <= fails;
    pending_o    <= due_results.size();
    checked_o    <= checked;
    underflows_o <= underflows;
    overflows_o  <= overflows;
  end

endmodule

[verif/stable_sorted_priority_queue_tb.sv]
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb
// Drives insert and remove beats into the sorted priority queue with random
// gaps and receiver stalls: a directed opening (empty remove, extreme words
// and priorities, ties, a full queue and an overflow) and then random bursts
// that swing the queue between empty and full. The checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sspq_pkg::*;

  localparam int Depth       = 16;
  localparam int RandomItems = 500;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               opcode_i;
  value_t             item_value_i;
  prio_t              item_priority_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [StatusW-1:0] status_o;
  value_t             removed_value_o;
  prio_t              removed_priority_o;
  logic [OccW-1:0]    occupancy_o;

  int errors;
  int pending;
  int checked;
  int underflows;
  int overflows;

  int sent;
  int hold_reqs;
  bit idle_on;

  stable_sorted_priority_queue #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .item_value_i      (item_value_i),
    .item_priority_i   (item_priority_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .removed_value_o   (removed_value_o),
    .removed_priority_o(removed_priority_o),
    .occupancy_o       (occupancy_o)
  );

  sspq_checker #(
    .QUEUE_DEPTH(Depth)
  ) checker_inst (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .item_value_i      (item_value_i),
    .item_priority_i   (item_priority_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_i          (status_o),
    .removed_value_i   (removed_value_o),
    .removed_priority_i(removed_priority_o),
    .occupancy_i       (occupancy_o),
    .errors_o          (errors),
    .pending_o         (pending),
    .checked_o         (checked),
    .underflows_o      (underflows),
    .overflows_o       (overflows)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #200us;
    $display("Timeout with %0d results still outstanding", pending);
    $display("stable_sorted_priority_queue verification failed");
    $finish;
  end

  // Extreme words now and then, otherwise fully random
  function automatic value_t pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Favor a narrow priority range so ties are frequent
  function automatic prio_t pick_prio();
    int r;
    r = $urandom_range(19);
    if (r < 12) return prio_t'($urandom_range(7));
    if (r < 17) return prio_t'($urandom);
    if (r == 17) return '0;
    return '1;
  endfunction

  // Offer one operation beat and hold it until accepted
  task automatic send_op(input logic op, input value_t v, input prio_t p);
    while (idle_on && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    item_value_i    <= v;
    item_priority_i <= p;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Stop offering beats until every predicted result has been returned
  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (served != hold_reqs) begin
        served    = hold_reqs;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (idle_on) begin
        out_stall_i <= ($urandom_range(99) < 17);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int rnd;
    int directed;
    int mode;
    int burst;
    int ins_pct;
    logic op;
    sent      = 0;
    rnd       = 0;
    hold_reqs = 0;
    idle_on   = 1'b1;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    opcode_i        <= OP_INSERT;
    item_value_i    <= '0;
    item_priority_i <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: remove on empty, extremes, ties, fill to the brim, overflow
    send_op(OP_REMOVE, 32'sh7FFF_FFFF, 16'hFFFF);
    send_op(OP_INSERT, 32'sh7FFF_FFFF, 16'hFFFF);
    send_op(OP_INSERT, 32'sh8000_0000, 16'h0000);
    send_op(OP_INSERT, '0, 16'd100);
    send_op(OP_INSERT, -32'sd1, 16'd100);
    send_op(OP_INSERT, 32'sd1, 16'd100);
    send_op(OP_INSERT, 32'sd2, 16'h0000);
    for (int i = 0; i < 10; i++) begin
      send_op(OP_INSERT, value_t'(i * 32'h1357_9BDF), prio_t'((i % 4) * 16'h5555));
    end
    send_op(OP_INSERT, 32'sd5, 16'd1);
    repeat (5) send_op(OP_REMOVE, pick_value(), pick_prio());
    directed = sent;

    // Random bursts that lean toward filling, draining or neither
    while (rnd < RandomItems) begin
      mode  = $urandom_range(2);
      burst = $urandom_range(40, 10);
      case (mode)
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      repeat (burst) begin
        op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        send_op(op, pick_value(), pick_prio());
        rnd++;
        // hold the receiver off while beats keep coming
        if (rnd == 100) hold_reqs++;
        if (rnd == 300) wait_drained();
        if (rnd == 350) idle_on = 1'b0;
        if (rnd == 450) idle_on = 1'b1;
      end
    end

    wait_drained();
    repeat (5) @(posedge clk_i);

    $display("Ran %0d operations (%0d directed, %0d random), %0d results compared.",
             sent, directed, rnd, checked);
    $display("Queue hit %0d underflows and %0d overflows; %0d failures, %0d unreturned.",
             underflows, overflows, errors, pending);
    if (errors == 0 && pending == 0) begin
      $display("stable_sorted_priority_queue verification clean");
    end else begin
      $display("stable_sorted_priority_queue verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/sspq_pkg.sv
rtl/core/sspq_cell.sv
rtl/core/stable_sorted_priority_queue.sv
verif/sspq_checker.sv
verif/stable_sorted_priority_queue_tb.sv
